[rtl/core/pabct_pkg.sv]
// Package for the per-address byte counter table: sizes, op codes and the
// command and status types between the controller and the datapath.
// No dependencies.
package pabct_pkg;

    // Table geometry. The address store is split into LANES memories so that
    // one row of LANES addresses is compared in each cycle of the scan.
    localparam int ENTRIES = 64;
    localparam int LANES   = 8;
    localparam int LANE_W  = $clog2(LANES);
    localparam int ROWS    = (ENTRIES + LANES - 1) / LANES;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOTS   = ROWS * LANES;
    localparam int SLOT_W  = ROW_W + LANE_W;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Payload widths.
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 64;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_ADD    = 2'd0;
    localparam t_op OP_LOOKUP = 2'd1;
    localparam t_op OP_DELETE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the incoming transaction and restart the scan
        logic scan;    // row scan of the address memories in progress
        logic commit;  // update the table and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // last row is being compared in this cycle
        logic out_busy;   // result register holds a result not yet taken
    } t_dp_status;

endpackage

[rtl/core/pabct_if.sv]
// Channel interfaces of the per-address byte counter table: the request
// channel and the result channel, each with valid, ready and payload.
// Depends on pabct_pkg.
interface pabct_in_if import pabct_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  ip_addr;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, output op, output ip_addr, output byte_count,
                    input ready);
    modport sink   (input valid, input op, input ip_addr, input byte_count,
                    output ready);
endinterface

interface pabct_out_if import pabct_pkg::*;;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               full_res;
    logic [TOTAL_W-1:0] byte_total;

    modport source (output valid, output hit, output full_res, output byte_total,
                    input ready);
    modport sink   (input valid, input hit, input full_res, input byte_total,
                    output ready);
endinterface

[rtl/core/per_address_byte_counter_table.sv]
// Top level of the per-address byte counter table: controller, datapath and
// the two channel interfaces.
// Depends on pabct_pkg, pabct_if, pabct_ctrl and pabct_dp.
//
//   Channel   Dir   Payload                          Handshake
//   i_in      in    op, ip_addr, byte_count          valid/ready
//   o_out     out   hit, full_res, byte_total        valid/ready
//
// LANES addresses of the address memories are compared per cycle over ROWS
// rows. Because the memories have a registered read, each row is compared
// from the RAM outputs after it is read. The scan is followed by a read of
// the byte-total memory, and then the commit updates the table and loads the
// result register; the commit waits while the result register is occupied.
// Input ready returns after the commit, so a new transaction is accepted only
// when the previous one has been committed.
// Reset is synchronous and active low; it clears the valid bit of every slot
// directly, so there is no clearing pass and the table is usable at once.
// The result sits in an output register. While it waits to be taken, the next
// request is accepted and scanned; only its commit waits for the register.
module per_address_byte_counter_table import pabct_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    pabct_in_if.sink    i_in,
    pabct_out_if.source o_out
);

    t_ctl_cmd   w_cmd;
    t_dp_status w_status;

    // The controller owns the request handshake; one transaction is in the
    // table logic at a time, so ready is high only between transactions.
    pabct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath latches the request on load, scans the table, and drives
    // the result channel from its output register.
    pabct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_op         (i_in.op),
        .i_ip_addr    (i_in.ip_addr),
        .i_byte_count (i_in.byte_count),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_hit        (o_out.hit),
        .o_full_res   (o_out.full_res),
        .o_byte_total (o_out.byte_total)
    );

endmodule

[rtl/core/pabct_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pabct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pabct_ctrl.sv]
// Controller of the per-address byte counter table: sequences accept, scan,
// byte-total read and commit for one transaction at a time.
// Depends on pabct_pkg.
module pabct_ctrl import pabct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.commit = (r_state == S_FIN) && !i_status.out_busy;

endmodule

[rtl/core/pabct_dp.sv]
// Datapath of the per-address byte counter table: lane address memories,
// byte-total memory, valid bits, scan logic and the result register.
// Depends on pabct_pkg and pabct_ram.
module pabct_dp import pabct_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    output t_dp_status         o_status,
    input  logic [OP_W-1:0]    i_op,
    input  logic [ADDR_W-1:0]  i_ip_addr,
    input  logic [COUNT_W-1:0] i_byte_count,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_hit,
    output logic               o_full_res,
    output logic [TOTAL_W-1:0] o_byte_total
);

    // Latched transaction.
    t_op                r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [COUNT_W-1:0] r_len;

    // Valid bit of every slot, arranged by row and lane.
    logic [LANES-1:0]   r_valid [ROWS];

    // Scan pipeline: r_row is the row being read, r_drow the row on the RAM outputs.
    logic               r_iss_on;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_drow;
    logic               r_dvld;

    // Scan results.
    logic               r_hit;
    logic [SLOT_W-1:0]  r_hslot;
    logic               r_free;
    logic [SLOT_W-1:0]  r_fslot;

    // Result register.
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_full;
    logic [TOTAL_W-1:0] r_out_total;

    logic [ADDR_W-1:0]  w_lane_rd [LANES];
    logic [LANES-1:0]   w_match;
    logic [LANES-1:0]   w_empty;
    logic [LANE_W-1:0]  w_match_lane;
    logic [LANE_W-1:0]  w_empty_lane;
    logic [TOTAL_W-1:0] w_bytes_rd;
    logic [TOTAL_W-1:0] w_sum;
    logic               w_insert;
    logic               w_bytes_we;
    logic [SLOT_W-1:0]  w_bytes_waddr;
    logic [TOTAL_W-1:0] w_bytes_wdata;
    logic               w_res_hit;
    logic               w_res_full;
    logic [TOTAL_W-1:0] w_res_total;
    logic               w_scan_done;
    logic               w_out_busy;
    logic [ROW_W-1:0]   w_frow;
    logic [LANE_W-1:0]  w_flane;
    logic [ROW_W-1:0]   w_hrow;
    logic [LANE_W-1:0]  w_hlane;

    assign w_frow  = r_fslot[SLOT_W-1:LANE_W];
    assign w_flane = r_fslot[LANE_W-1:0];
    assign w_hrow  = r_hslot[SLOT_W-1:LANE_W];
    assign w_hlane = r_hslot[LANE_W-1:0];

    // Compare one row of addresses; slots past the table's end count as absent.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            logic exists;
            exists     = ((int'(r_drow) * LANES + k) < ENTRIES);
            w_match[k] = exists && r_valid[r_drow][k] && (w_lane_rd[k] == r_addr);
            w_empty[k] = exists && !r_valid[r_drow][k];
        end
    end

    always_comb begin
        w_match_lane = '0;
        w_empty_lane = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_match_lane = LANE_W'(k);
            end
            if (w_empty[k]) begin
                w_empty_lane = LANE_W'(k);
            end
        end
    end

    assign w_scan_done = r_dvld && (r_drow == LAST_ROW);
    assign w_out_busy  = r_out_valid && !i_out_ready;

    assign o_status.scan_done = w_scan_done;
    assign o_status.out_busy  = w_out_busy;

    // Result and table update of the commit cycle.
    assign w_sum    = w_bytes_rd + TOTAL_W'(r_len);
    assign w_insert = (r_op == OP_ADD) && !r_hit && r_free;

    always_comb begin
        w_res_hit   = 1'b0;
        w_res_full  = 1'b0;
        w_res_total = '0;
        case (r_op)
            OP_ADD: begin
                if (r_hit) begin
                    w_res_hit   = 1'b1;
                    w_res_total = w_sum;
                end else if (r_free) begin
                    w_res_total = TOTAL_W'(r_len);
                end else begin
                    w_res_full  = 1'b1;
                end
            end
            OP_LOOKUP, OP_DELETE: begin
                if (r_hit) begin
                    w_res_hit   = 1'b1;
                    w_res_total = w_bytes_rd;
                end
            end
            default: begin
                w_res_hit = 1'b0;
            end
        endcase
    end

    assign w_bytes_we    = i_cmd.commit && (r_op == OP_ADD) && (r_hit || r_free);
    assign w_bytes_waddr = r_hit ? r_hslot : r_fslot;
    assign w_bytes_wdata = r_hit ? w_sum : TOTAL_W'(r_len);

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            pabct_ram #(
                .WIDTH (ADDR_W),
                .DEPTH (ROWS)
            ) u_addr_ram (
                .i_clk   (i_clk),
                .i_we    (i_cmd.commit && w_insert && (w_flane == LANE_W'(g))),
                .i_waddr (w_frow),
                .i_wdata (r_addr),
                .i_raddr (r_row),
                .o_rdata (w_lane_rd[g])
            );
        end
    endgenerate

    pabct_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (SLOTS)
    ) u_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (w_bytes_we),
        .i_waddr (w_bytes_waddr),
        .i_wdata (w_bytes_wdata),
        .i_raddr (r_hslot),
        .o_rdata (w_bytes_rd)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_addr <= i_ip_addr;
            r_len  <= i_byte_count;
        end
        if (i_cmd.load) begin
            r_row <= '0;
        end else if (i_cmd.scan && r_iss_on && (r_row != LAST_ROW)) begin
            r_row <= r_row + 1'b1;
        end
        if (i_cmd.scan) begin
            r_drow <= r_row;
        end
        if (i_cmd.scan && r_dvld && (|w_match) && !r_hit) begin
            r_hslot <= {r_drow, w_match_lane};
        end
        if (i_cmd.scan && r_dvld && (|w_empty) && !r_free) begin
            r_fslot <= {r_drow, w_empty_lane};
        end
        if (i_cmd.commit) begin
            r_out_hit   <= w_res_hit;
            r_out_full  <= w_res_full;
            r_out_total <= w_res_total;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_on    <= 1'b0;
            r_dvld      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_valid[r] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_iss_on <= 1'b1;
                r_dvld   <= 1'b0;
                r_hit    <= 1'b0;
                r_free   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_dvld <= r_iss_on;
                if (r_iss_on && (r_row == LAST_ROW)) begin
                    r_iss_on <= 1'b0;
                end
                if (r_dvld && (|w_match)) begin
                    r_hit <= 1'b1;
                end
                if (r_dvld && (|w_empty)) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.commit && w_insert) begin
                r_valid[w_frow][w_flane] <= 1'b1;
            end
            if (i_cmd.commit && (r_op == OP_DELETE) && r_hit) begin
                r_valid[w_hrow][w_hlane] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_full_res   = r_out_full;
    assign o_byte_total = r_out_total;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !w_out_busy)
        else $error("commit while the result register is still occupied");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit did not load the result register");

    a_scan_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_done |=> !w_scan_done)
        else $error("scan completion seen in two successive cycles");

    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_insert) |-> !r_valid[w_frow][w_flane])
        else $error("insert into a slot that is already in use");
`endif

endmodule
